// ===== rtl/fhc_pkg.sv =====
package fhc_pkg;

    localparam int DEPTH_DEF        = 256;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int OP_W  = 2;
    localparam int KEY_W = 64;
    localparam int PAY_W = 32;
    localparam int CNT_W = 9;

    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRIM,
        ST_SCAN,
        ST_APPLY
    } t_state;

endpackage

// ===== rtl/fhc_in_if.sv =====
interface fhc_in_if import fhc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload_in;

    modport source (output valid, output opcode, output key, output payload_in, input ready);
    modport sink   (input valid, input opcode, input key, input payload_in, output ready);
endinterface

// ===== rtl/fhc_out_if.sv =====
interface fhc_out_if import fhc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [PAY_W-1:0] payload_out;
    logic [CNT_W-1:0] occupancy;

    modport source (output valid, output found, output payload_out, output occupancy, input ready);
    modport sink   (input valid, input found, input payload_out, input occupancy, output ready);
endinterface

// ===== rtl/fhc_store.sv =====
module fhc_store import fhc_pkg::*; #(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic [$clog2(DEPTH)-1:0]                       i_rd_addr,
    input  logic                                           i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]                       i_wr_addr,
    input  logic [KEY_W-1:0]                               i_wr_key,
    input  logic [(PAYLOAD_BITS < PAY_W ? PAYLOAD_BITS : PAY_W)-1:0] i_wr_pay,
    output logic [KEY_W-1:0]                               o_rd_key,
    output logic [(PAYLOAD_BITS < PAY_W ? PAYLOAD_BITS : PAY_W)-1:0] o_rd_pay
);

    localparam int STORE_W = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;

    logic [KEY_W-1:0]   key_mem [DEPTH];
    logic [STORE_W-1:0] pay_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            key_mem[i_wr_addr] <= i_wr_key;
            pay_mem[i_wr_addr] <= i_wr_pay;
        end
        o_rd_key <= key_mem[i_rd_addr];
        o_rd_pay <= pay_mem[i_rd_addr];
    end

endmodule

// ===== rtl/fhc_seq.sv =====
module fhc_seq import fhc_pkg::*; #(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_cfg_wr_en,
    input  logic [CNT_W-1:0]                               i_cfg_wr_data,
    input  logic                                           i_in_valid,
    output logic                                           o_in_ready,
    input  logic [OP_W-1:0]                                i_opcode,
    input  logic [KEY_W-1:0]                               i_key,
    input  logic [PAY_W-1:0]                               i_payload_in,
    output logic                                           o_out_valid,
    input  logic                                           i_out_ready,
    output logic                                           o_found,
    output logic [PAY_W-1:0]                               o_payload_out,
    output logic [CNT_W-1:0]                               o_occupancy,
    output logic [$clog2(DEPTH)-1:0]                       o_rd_addr,
    output logic                                           o_wr_en,
    output logic [$clog2(DEPTH)-1:0]                       o_wr_addr,
    output logic [KEY_W-1:0]                               o_wr_key,
    output logic [(PAYLOAD_BITS < PAY_W ? PAYLOAD_BITS : PAY_W)-1:0] o_wr_pay,
    input  logic [KEY_W-1:0]                               i_rd_key,
    input  logic [(PAYLOAD_BITS < PAY_W ? PAYLOAD_BITS : PAY_W)-1:0] i_rd_pay
);

    localparam int STORE_W = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int SUM_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST    = IDX_W'(DEPTH - 1);

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [STORE_W-1:0] r_pay, n_pay;
    logic [CNT_W-1:0]   r_cap;
    logic [IDX_W-1:0]   r_oldest, n_oldest;
    logic [CNT_W-1:0]   r_live, n_live;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic               r_pend, n_pend;
    logic               r_hit, n_hit;
    logic [STORE_W-1:0] r_hit_pay, n_hit_pay;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic [PAY_W-1:0]   r_out_pay, n_out_pay;
    logic [CNT_W-1:0]   r_out_occ, n_out_occ;

    logic [SUM_W-1:0]   cap_ext;
    logic [CNT_W-1:0]   eff_cap;
    logic               over;
    logic [CNT_W-1:0]   drop;
    logic [SUM_W-1:0]   trim_sum;
    logic [IDX_W-1:0]   trim_old;
    logic [SUM_W-1:0]   tail_sum;
    logic [IDX_W-1:0]   tail;
    logic [IDX_W-1:0]   oldest_inc;
    logic [IDX_W-1:0]   ptr_inc;
    logic               match;

    always_comb begin
        cap_ext    = SUM_W'(r_cap);
        eff_cap    = (cap_ext > DEPTH_S) ? CNT_W'(DEPTH_S) : r_cap;
        over       = r_live > eff_cap;
        drop       = r_live - eff_cap;
        trim_sum   = SUM_W'(r_oldest) + SUM_W'(drop);
        trim_old   = (trim_sum >= DEPTH_S) ? IDX_W'(trim_sum - DEPTH_S) : IDX_W'(trim_sum);
        tail_sum   = SUM_W'(r_oldest) + SUM_W'(r_live);
        tail       = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
        oldest_inc = (r_oldest == LAST) ? '0 : r_oldest + 1'b1;
        ptr_inc    = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;
        match      = r_pend && (i_rd_key == r_key);
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_pay       = r_pay;
        n_oldest    = r_oldest;
        n_live      = r_live;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_hit_pay   = r_hit_pay;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_found = r_out_found;
        n_out_pay   = r_out_pay;
        n_out_occ   = r_out_occ;
        o_in_ready  = 1'b0;
        o_rd_addr   = r_ptr;
        o_wr_en     = 1'b0;
        o_wr_addr   = tail;
        o_wr_key    = r_key;
        o_wr_pay    = r_pay;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = t_op'(i_opcode);
                    n_key   = i_key;
                    n_pay   = i_payload_in[STORE_W-1:0];
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (over) begin
                    n_oldest = trim_old;
                    n_live   = eff_cap;
                end
                n_ptr  = over ? trim_old : r_oldest;
                n_cnt  = '0;
                n_pend = 1'b0;
                n_hit  = 1'b0;
                if (r_op == OP_LOOKUP || r_op == OP_INSERT) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_APPLY;
                end
            end
            ST_SCAN: begin
                n_pend = 1'b0;
                if (r_cnt != r_live) begin
                    n_pend = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_ptr  = ptr_inc;
                end
                if (match) begin
                    n_hit     = 1'b1;
                    n_hit_pay = i_rd_pay;
                    n_state   = ST_APPLY;
                end else if (r_cnt == r_live && !r_pend) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b0;
                    n_out_pay   = '0;
                    n_out_occ   = r_live;
                    case (r_op)
                        OP_LOOKUP: begin
                            n_out_found = r_hit;
                            n_out_pay   = r_hit ? PAY_W'(r_hit_pay) : '0;
                        end
                        OP_INSERT: begin
                            if (r_hit) begin
                                n_out_found = 1'b1;
                            end else begin
                                o_wr_en = 1'b1;
                                if (r_live == eff_cap) begin
                                    n_oldest = oldest_inc;
                                end else begin
                                    n_live    = r_live + 1'b1;
                                    n_out_occ = r_live + 1'b1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_oldest  = '0;
                            n_live    = '0;
                            n_out_occ = '0;
                        end
                        OP_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_oldest    <= '0;
            r_live      <= '0;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            r_oldest    <= n_oldest;
            r_live      <= n_live;
            r_cnt       <= n_cnt;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_pay       <= n_pay;
        r_hit_pay   <= n_hit_pay;
        r_out_found <= n_out_found;
        r_out_pay   <= n_out_pay;
        r_out_occ   <= n_out_occ;
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_payload_out = r_out_pay;
    assign o_occupancy   = r_out_occ;

endmodule

// ===== rtl/fifo_replacement_hash_cache.sv =====
// From accept to result: a trim step, a key scan of at most the live entries
// (one live entry read a cycle from the key store), and an apply step that waits
// while an earlier result is not yet taken. Ready only while the sequencer is idle,
// so a new request is not accepted before the previous one has gone through apply.
// Reset (synchronous, active low) empties the cache and sets capacity to 256;
// stored keys and payloads are not cleared.
module fifo_replacement_hash_cache import fhc_pkg::*; #(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    fhc_in_if.sink           i_req,
    fhc_out_if.source        o_rsp
);

    localparam int STORE_W = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam int IDX_W   = $clog2(DEPTH);

    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_W-1:0]   wr_key;
    logic [STORE_W-1:0] wr_pay;
    logic [KEY_W-1:0]   rd_key;
    logic [STORE_W-1:0] rd_pay;

    fhc_store #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_pay  (wr_pay),
        .o_rd_key  (rd_key),
        .o_rd_pay  (rd_pay)
    );

    fhc_seq #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_req.valid),
        .o_in_ready    (i_req.ready),
        .i_opcode      (i_req.opcode),
        .i_key         (i_req.key),
        .i_payload_in  (i_req.payload_in),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_found       (o_rsp.found),
        .o_payload_out (o_rsp.payload_out),
        .o_occupancy   (o_rsp.occupancy),
        .o_rd_addr     (rd_addr),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_key      (wr_key),
        .o_wr_pay      (wr_pay),
        .i_rd_key      (rd_key),
        .i_rd_pay      (rd_pay)
    );

endmodule
